@@ hdl/bloom_filter_engine_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Bloom filter engine assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_ENGINE_UNIT_MACROS_SVH
`define BLOOM_FILTER_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BFE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/bfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Bloom filter engine package
// Payload structs, command codes, sequencer states and hash constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfe_pkg;
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic [0:0] REG_FILTER_BITS = 1'b0;
	localparam logic [0:0] REG_HASH_COUNT  = 1'b1;
	localparam logic [31:0] MM_MUL = 32'h5bd1e995;
	localparam logic [4:0] HASH_LIMIT = 5'd16;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
	} req_t;

	typedef struct packed {
		logic        present;
		logic [31:0] element_count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_M0,   // blk *= M (block 0 or 1)
		ST_M1,   // blk ^= blk>>24; blk *= M
		ST_M2,   // h *= M
		ST_F0,   // h ^= h>>13; h *= M
		ST_F1,   // h ^= h>>15, start modulo
		ST_MOD,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ hdl/bfe_mod.sv @@
// ----------------------------------------------------------------------------
// Bloom filter engine modulo unit
// Restoring division remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfe_mod
	import bfe_pkg::*;
#(
	parameter int unsigned DW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      rem
);
	logic [DW:0]   rem_q;
	logic [31:0]   num_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [DW+1:0] trial;

	assign trial = {rem_q, num_q[31]} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			if (!trial[DW+1])
				rem_q <= trial[DW:0];
			else
				rem_q <= {rem_q[DW-1:0], num_q[31]};
		end
	end

	assign done = !busy_q && !start;
	assign rem  = rem_q[DW-1:0];
endmodule
`default_nettype wire

@@ hdl/bloom_filter_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Bloom filter engine
// Insert / query / flush over 64-bit keys with seeded MurmurHash2 positions.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// req     | in  | req_valid/ready  | req_t {command, key}
// rsp     | out | rsp_valid/ready  | rsp_t {present, element_count}
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// One request at a time. Each hash runs its mixing steps on the shared 32x32
// multiplier, starts the modulo, waits on the serial modulo unit and ends with
// a store read-modify-write; rsp_valid rises after the last hash (a query
// stops at its first clear bit). A flush clears every store word. After reset
// a clearing pass runs before req_ready. The response register frees once
// taken; a new request waits for that.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bloom_filter_engine_unit_macros.svh"
module bloom_filter_engine_unit
	import bfe_pkg::*;
#(
	parameter int unsigned MAX_BITS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	localparam int unsigned WORDS = (MAX_BITS + 63) / 64;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned PW    = $clog2(MAX_BITS) + 1;  // holds MAX_BITS

	// configuration
	logic [12:0] filter_bits_q;
	logic [4:0]  hash_count_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= 13'd4096;
			hash_count_q  <= 5'd7;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FILTER_BITS)
				filter_bits_q <= cfg_data;
			else
				hash_count_q <= cfg_data[4:0];
		end
	end

	// effective bit count, compared at PW+13 bits to stay general
	logic [PW-1:0] eff_m;
	always_comb begin
		if (filter_bits_q == 13'd0)
			eff_m = PW'(1);
		else if ({{PW{1'b0}}, filter_bits_q} > (PW+13)'(MAX_BITS))
			eff_m = PW'(MAX_BITS);
		else
			eff_m = PW'(filter_bits_q);
	end
	logic [4:0] eff_k;
	assign eff_k = (hash_count_q > HASH_LIMIT) ? HASH_LIMIT : hash_count_q;

	// sequencer state
	state_t      state_q, state_d;
	cmd_t        cmd_q;
	logic [63:0] key_q;
	logic [4:0]  idx_q;
	logic        blk_q;      // which key block is being mixed
	logic [31:0] h_q, b_q;
	logic        present_q;
	logic [31:0] count_q;
	logic [AW-1:0] clr_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// shared multiplier by the MurmurHash constant
	logic [31:0] mul_in, mul_out;
	assign mul_out = mul_in * MM_MUL;
	always_comb begin
		unique case (state_q)
			ST_M0:   mul_in = blk_q ? key_q[63:32] : key_q[31:0];
			ST_M1:   mul_in = b_q ^ (b_q >> 24);
			ST_F0:   mul_in = h_q ^ (h_q >> 13);
			default: mul_in = h_q;
		endcase
	end

	// modulo unit
	logic          mod_start, mod_done;
	logic [PW-1:0] mod_rem;
	bfe_mod #(.DW(PW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.dividend(h_q ^ (h_q >> 15)), .divisor(eff_m),
		.done(mod_done), .rem(mod_rem)
	);
	assign mod_start = (state_q == ST_F1);

	// bit store: one read port, one write port, read data registered
	logic [63:0]   mem [WORDS];
	logic [63:0]   rd_s1;
	logic [AW-1:0] waddr;
	logic [63:0]   wdata;
	logic          wen;
	logic [AW-1:0] word_addr;
	logic [5:0]    bit_sel;
	assign bit_sel = mod_rem[5:0];
	generate
		if (WORDS > 1) begin : g_addr
			assign word_addr = AW'(mod_rem >> 6);
		end else begin : g_addr1
			assign word_addr = '0;
		end
	endgenerate
	always_ff @(posedge clk) begin
		if (wen)
			mem[waddr] <= wdata;
		rd_s1 <= mem[word_addr];
	end
	always_comb begin
		wen   = 1'b0;
		waddr = word_addr;
		wdata = rd_s1 | (64'd1 << bit_sel);
		if (state_q == ST_CLEAR) begin
			wen   = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == ST_WR && cmd_q == CMD_INSERT) begin
			wen = 1'b1;
		end
	end

	logic last_hash;
	assign last_hash = (idx_q + 5'd1 >= eff_k);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && req_ready) begin
					if (req.command == CMD_FLUSH)
						state_d = ST_CLEAR;
					else if ((req.command == CMD_INSERT || req.command == CMD_QUERY)
							&& eff_k != 5'd0)
						state_d = ST_M0;
					else
						state_d = ST_DONE;
				end
			end
			// the pass after reset has no request behind it and gives no response
			ST_CLEAR: begin
				if (clr_q == AW'(WORDS - 1))
					state_d = (cmd_q == CMD_FLUSH) ? ST_DONE : ST_IDLE;
			end
			ST_M0:    state_d = ST_M1;
			ST_M1:    state_d = ST_M2;
			ST_M2:    state_d = blk_q ? ST_F0 : ST_M0;
			ST_F0:    state_d = ST_F1;
			ST_F1:    state_d = ST_MOD;
			ST_MOD:   if (mod_done) state_d = ST_RD;
			ST_RD:    state_d = ST_WR;
			ST_WR: begin
				if (last_hash || (cmd_q == CMD_QUERY && !rd_s1[bit_sel]))
					state_d = ST_DONE;
				else
					state_d = ST_M0;
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	assign req_ready = (state_q == ST_IDLE) && !rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			cmd_q       <= CMD_NONE;
			idx_q       <= '0;
			blk_q       <= 1'b0;
			present_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						cmd_q     <= cmd_t'(req.command);
						idx_q     <= '0;
						blk_q     <= 1'b0;
						clr_q     <= '0;
						present_q <= (req.command == CMD_QUERY);
					end
				end
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_M2:    blk_q <= ~blk_q;
				ST_WR: begin
					idx_q <= idx_q + 5'd1;
					if (cmd_q == CMD_QUERY && !rd_s1[bit_sel])
						present_q <= 1'b0;
				end
				ST_DONE: begin
					if (cmd_q == CMD_FLUSH)
						count_q <= '0;
					else if (cmd_q == CMD_INSERT && count_q != 32'hFFFF_FFFF)
						count_q <= count_q + 32'd1;
					rsp_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// hash datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid && req_ready) begin
			key_q <= req.key;
			h_q   <= 32'd8;
		end
		unique case (state_q)
			ST_M0: b_q <= mul_out;
			ST_M1: b_q <= mul_out;
			ST_M2: h_q <= mul_out ^ b_q;
			ST_F0: h_q <= mul_out;
			ST_WR: h_q <= {27'd0, idx_q + 5'd1} ^ 32'd8;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			rsp_q.present <= (cmd_q == CMD_QUERY) ? present_q : 1'b0;
			if (cmd_q == CMD_FLUSH)
				rsp_q.element_count <= '0;
			else if (cmd_q == CMD_INSERT && count_q != 32'hFFFF_FFFF)
				rsp_q.element_count <= count_q + 32'd1;
			else
				rsp_q.element_count <= count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BFE_ASSERT_IMPL(a_no_req_busy, clk, arst_n, state_q != ST_IDLE, !req_ready)
	`BFE_ASSERT_NEXT(a_done_rsp, clk, arst_n, state_q == ST_DONE, rsp_valid)
	`BFE_ASSERT_IMPL(a_rsp_idle, clk, arst_n, rsp_valid, state_q == ST_IDLE)
endmodule
`default_nettype wire

@@ bench/bloom_filter_engine_unit_checker.sv @@
// ----------------------------------------------------------------------------
// Bloom filter engine checker
// Watches the request, response and config channels, keeps a shadow filter
// and compares every response against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bloom_filter_engine_unit_checker
	import bfe_pkg::*;
#(
	parameter int unsigned MAX_BITS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	logic [MAX_BITS-1:0] shadow_bits;
	logic [31:0]         shadow_count;
	logic [12:0]         shadow_size;
	logic [4:0]          shadow_hashes;
	rsp_t                expected_rsps[$];

	function automatic logic [31:0] mm_block(logic [31:0] h, logic [31:0] blk);
		blk = blk * MM_MUL;
		blk = blk ^ (blk >> 24);
		blk = blk * MM_MUL;
		h = h * MM_MUL;
		return h ^ blk;
	endfunction

	function automatic logic [31:0] key_hash(logic [63:0] key, logic [31:0] seed);
		logic [31:0] h;
		h = seed ^ 32'd8;
		h = mm_block(h, key[31:0]);
		h = mm_block(h, key[63:32]);
		h = h ^ (h >> 13);
		h = h * MM_MUL;
		return h ^ (h >> 15);
	endfunction

	// apply one request to the shadow filter and return its response
	function automatic rsp_t filter_apply(req_t r);
		rsp_t        o;
		logic [31:0] m, k, pos;
		m = (shadow_size == 0) ? 1 : (shadow_size > MAX_BITS ? MAX_BITS : shadow_size);
		k = (shadow_hashes > HASH_LIMIT) ? HASH_LIMIT : shadow_hashes;
		o.present = 1'b0;
		case (cmd_t'(r.command))
			CMD_INSERT: begin
				for (int i = 0; i < k; i++) begin
					pos = key_hash(r.key, i) % m;
					shadow_bits[pos] = 1'b1;
				end
				if (shadow_count != 32'hFFFF_FFFF)
					shadow_count++;
			end
			CMD_QUERY: begin
				o.present = 1'b1;
				for (int i = 0; i < k; i++) begin
					pos = key_hash(r.key, i) % m;
					if (!shadow_bits[pos])
						o.present = 1'b0;
				end
			end
			CMD_FLUSH: begin
				shadow_bits = '0;
				shadow_count = '0;
			end
			default: ;
		endcase
		o.element_count = shadow_count;
		return o;
	endfunction

	assign pending = expected_rsps.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_bits <= '0;
			shadow_count <= '0;
			shadow_size <= 13'd4096;
			shadow_hashes <= 5'd7;
			fail_count <= 0;
			expected_rsps.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FILTER_BITS)
					shadow_size = cfg_data;
				else
					shadow_hashes = cfg_data[4:0];
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(filter_apply(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response %p", rsp);
					fail_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.present !== want.present) begin
						$error("present: expected %0d actual %0d", want.present, rsp.present);
						fail_count++;
					end
					if (rsp.element_count !== want.element_count) begin
						$error("element_count: expected %0d actual %0d",
							want.element_count, rsp.element_count);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

@@ bench/bloom_filter_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// Bloom filter engine testbench
// Drives insert/query/flush requests with random gaps and backpressure over
// several filter sizes and hash counts; a checker predicts the responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bloom_filter_engine_unit_test;
	import bfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_FILTER_BITS;
	logic [12:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	bit          no_gaps = 1'b0;     // last part of the run idles on neither side
	bit          long_hold = 1'b0;   // receiver holds off to fill the block
	int          quiet_cycles = 0;
	logic [63:0] recent_keys[$];

	bloom_filter_engine_unit dut (.*);

	bloom_filter_engine_unit_checker chk (.*);

	initial forever #6 clk = ~clk;

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// response side: random stall bursts, one long hold-off on request
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (1500) @(negedge clk);
				long_hold = 1'b0;
			end
			if (!no_gaps && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				run = $urandom_range(1, 15);
				repeat (run - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// valid stays up after an accept; the next call either reloads it or
	// drops it for a gap, so each falling edge sees one update
	task automatic send_request(cmd_t cmd, logic [63:0] key);
		if (!no_gaps && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req.command <= cmd;
		req.key <= key;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// wait for every response, then let a possible trailing op settle
	task automatic drain;
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (800) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// mostly inserts and queries, with keys that often repeat earlier inserts
	task automatic random_request;
		logic [63:0] key;
		int sel;
		sel = $urandom_range(0, 99);
		key = {$urandom, $urandom};
		if (recent_keys.size() != 0 && $urandom_range(0, 1))
			key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		if (sel < 45) begin
			send_request(CMD_INSERT, key);
			recent_keys.push_back(key);
			if (recent_keys.size() > 32)
				void'(recent_keys.pop_front());
		end else if (sel < 92) begin
			send_request(CMD_QUERY, key);
		end else if (sel < 96) begin
			send_request(CMD_FLUSH, key);
			recent_keys.delete();
		end else begin
			send_request(CMD_NONE, key);
		end
	endtask

	initial begin
		logic [12:0] sizes[7] = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd64, 13'd777, 13'd4096};
		logic [12:0] hashes[7] = '{13'd16, 13'd1, 13'd0, 13'd31, 13'd3, 13'd17, 13'd7};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset config, key extremes, every command
		send_request(CMD_QUERY, 64'h0);
		send_request(CMD_INSERT, 64'h0);
		send_request(CMD_QUERY, 64'h0);
		send_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(CMD_QUERY, 64'h5555_AAAA_5555_AAAA);
		send_request(CMD_INSERT, 64'hAAAA_5555_AAAA_5555);
		send_request(CMD_NONE, 64'h1234_5678_9ABC_DEF0);
		send_request(CMD_FLUSH, 64'h0);
		send_request(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);

		// backpressure: hold responses while requests keep coming
		long_hold = 1'b1;
		repeat (6) send_request(CMD_INSERT, {$urandom, $urandom});
		drain();

		// random phases over several settings; last phase without gaps
		foreach (sizes[p]) begin
			write_reg(REG_FILTER_BITS, sizes[p]);
			write_reg(REG_HASH_COUNT, hashes[p]);
			recent_keys.delete();
			if (p == 6)
				no_gaps = 1'b1;
			// zero/one-bit filters saturate fast; keep those phases short
			repeat ((sizes[p] < 2) ? 60 : 300) random_request();
			drain();
		end

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
